FILE: sv/frd_pkg.sv
// Shared constants and formats of the Fresnel reflectance pipeline.
package frd_pkg;

  // Working fraction width of cosines, sines and Fresnel quotients (Q30).
  localparam int WORK_BITS = 30;
  // Square root: radicand up to 2^60, root up to 2^30.
  localparam int ROOT_W    = WORK_BITS + 1;
  localparam int RAD_W     = 2 * ROOT_W;
  // Refractive indices, unsigned Q2.14.
  localparam int INDEX_W   = 16;
  localparam logic [INDEX_W-1:0] INDEX_ONE   = 16'd16384;
  localparam logic [INDEX_W-1:0] INDEX_RESET = 16'd24576;

endpackage

FILE: sv/fresnel_reflectance_dielectric.sv
// Top level: unpolarized Fresnel reflectance of a dielectric interface.
//
//   channel   direction  handshake                  payload
//   -------   ---------  -------------------------  ---------------------------------
//   in        in         in_valid_i / in_ready_o    incident_*_i, normal_*_i (Q2.14)
//   out       out        out_valid_o / out_ready_i  reflectance_o (Q1.16), total_internal_o
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_data_i (material index, Q2.14)
//
// One request enters per cycle while the pipeline is not held. The pipeline
// has 131 register stages; most of them lie in the two 31-stage square root
// units and two 30-stage divides in series (the s and p dividers run side by
// side), each resolving one bit per stage. Reset clears every valid bit and
// loads the material index with 1.5. When the output register holds a result
// that is not taken, the whole pipeline holds; nothing is dropped or repeated.
module fresnel_reflectance_dielectric #(
  parameter int FRACTION_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  incident_x_i,
  input  logic signed [15:0]  incident_y_i,
  input  logic signed [15:0]  incident_z_i,
  input  logic signed [15:0]  normal_x_i,
  input  logic signed [15:0]  normal_y_i,
  input  logic signed [15:0]  normal_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [16:0]         reflectance_o,
  output logic                total_internal_o
);
  import frd_pkg::*;

  localparam int DotW  = 34;
  localparam int OneSh = 2 * FRACTION_BITS;
  localparam int ShR   = (OneSh >= WORK_BITS) ? OneSh - WORK_BITS : 0;
  localparam int ShL   = (OneSh <  WORK_BITS) ? WORK_BITS - OneSh : 0;
  localparam int ProdW = INDEX_W + ROOT_W;   // index times a Q30 value
  localparam logic [RAD_W-1:0] RadOne = RAD_W'(1) << (2 * WORK_BITS);

  typedef struct packed {
    logic [ROOT_W-1:0]  c;
    logic [INDEX_W-1:0] etai;
    logic [INDEX_W-1:0] etat;
  } geo_t;

  typedef struct packed {
    geo_t g;
    logic tir;
  } geo_tir_t;

  typedef struct packed {
    logic tir;
    logic sat;
  } flag_t;

  // Global advance: hold everything while a finished result waits.
  logic adv;
  assign adv        = !(out_valid_o && !out_ready_i);
  assign in_ready_o = adv;

  // Material index register.
  logic [INDEX_W-1:0] inner_index_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_index_q <= INDEX_RESET;
    end else if (cfg_valid_i) begin
      inner_index_q <= cfg_data_i;
    end
  end

  // Stage 1: component products.
  logic               v1_q;
  logic signed [31:0] p0_q, p1_q, p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q <= incident_x_i * normal_x_i;
      p1_q <= incident_y_i * normal_y_i;
      p2_q <= incident_z_i * normal_z_i;
    end
  end

  // Stage 2: dot product, clamp to magnitude one, cosine in Q30, pick indices.
  logic signed [DotW-1:0] dot;
  logic [DotW-1:0]        mag, mag_cl;
  logic                   over, leaving;
  logic                   v2_q;
  geo_t                   g2_d, g2_q;

  assign dot     = DotW'(p0_q) + DotW'(p1_q) + DotW'(p2_q);
  assign mag     = dot[DotW-1] ? DotW'(-dot) : DotW'(dot);
  assign over    = (OneSh < DotW) && (mag > (DotW'(1) << OneSh));
  assign mag_cl  = over ? (DotW'(1) << OneSh) : mag;
  // Positive cosine: the ray leaves the material, so swap the indices.
  assign leaving = !dot[DotW-1] && (dot != '0);

  always_comb begin
    g2_d.c    = ROOT_W'((mag_cl >> ShR) << ShL);
    g2_d.etai = leaving ? inner_index_q : INDEX_ONE;
    g2_d.etat = leaving ? INDEX_ONE : inner_index_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g2_q <= g2_d;
    end
  end

  // Stage 3: cosine squared.
  logic              v3_q;
  logic [RAD_W-1:0]  csq_q;
  geo_t              g3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      csq_q <= g2_q.c * g2_q.c;
      g3_q  <= g2_q;
    end
  end

  // Incident sine = sqrt(1 - cos^2).
  logic              v4;
  logic [ROOT_W-1:0] s4;
  logic [$bits(geo_t)-1:0] g4_raw;
  geo_t              g4;

  frd_isqrt #(
    .SIDE_W ($bits(geo_t))
  ) u_sqrt_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   (RadOne - csq_q),
    .side_i  (g3_q),
    .valid_o (v4),
    .root_o  (s4),
    .side_o  (g4_raw)
  );
  assign g4 = geo_t'(g4_raw);

  // Stage 5: sine times incident index.
  logic              v5_q;
  logic [ProdW-1:0]  se_q;
  geo_t              g5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      se_q <= s4 * g4.etai;
      g5_q <= g4;
    end
  end

  // Total internal reflection test, then transmitted sine = s*etai/etat.
  geo_tir_t                side5;
  logic                    v6;
  logic [WORK_BITS-1:0]    sint6;
  logic [$bits(geo_tir_t)-1:0] side6_raw;
  geo_tir_t                side6;

  always_comb begin
    side5.g   = g5_q;
    side5.tir = se_q >= {1'b0, g5_q.etat, {WORK_BITS{1'b0}}};
  end

  frd_div #(
    .DEN_W  (INDEX_W + 1),
    .SIDE_W ($bits(geo_tir_t))
  ) u_div_sint (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v5_q),
    .num_i   (se_q[ProdW-1:WORK_BITS]),
    .low_i   (se_q[WORK_BITS-1:0]),
    .den_i   ({1'b0, g5_q.etat}),
    .side_i  (side5),
    .valid_o (v6),
    .quo_o   (sint6),
    .side_o  (side6_raw)
  );
  assign side6 = geo_tir_t'(side6_raw);

  // Stage 7: transmitted sine squared.
  logic                 v7_q;
  logic [RAD_W-1:0]     ssq_q;
  geo_tir_t             side7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv) begin
      v7_q <= v6;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ssq_q   <= RAD_W'(sint6) * RAD_W'(sint6);
      side7_q <= side6;
    end
  end

  // Transmitted cosine = sqrt(1 - sint^2).
  logic                        v8;
  logic [ROOT_W-1:0]           cost8;
  logic [$bits(geo_tir_t)-1:0] side8_raw;
  geo_tir_t                    side8;

  frd_isqrt #(
    .SIDE_W ($bits(geo_tir_t))
  ) u_sqrt_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v7_q),
    .rad_i   (RadOne - ssq_q),
    .side_i  (side7_q),
    .valid_o (v8),
    .root_o  (cost8),
    .side_o  (side8_raw)
  );
  assign side8 = geo_tir_t'(side8_raw);

  // Stage 9: the four index products of the s and p terms.
  logic             v9_q, tir9_q;
  logic [ProdW-1:0] pa1_q, pb1_q, pa2_q, pb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v9_q <= 1'b0;
    end else if (adv) begin
      v9_q <= v8;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa1_q  <= side8.g.etat * side8.g.c;
      pb1_q  <= side8.g.etai * cost8;
      pa2_q  <= side8.g.etai * side8.g.c;
      pb2_q  <= side8.g.etat * cost8;
      tir9_q <= side8.tir;
    end
  end

  // Stage 10: numerators, denominators and the full-reflection flags.
  logic             v10_q, tir10_q, sat1_q, sat2_q;
  logic [ProdW-1:0] num1_q, den1_q, num2_q, den2_q;
  logic [ProdW-1:0] num1_d, den1_d, num2_d, den2_d;

  assign num1_d = (pa1_q > pb1_q) ? pa1_q - pb1_q : pb1_q - pa1_q;
  assign den1_d = pa1_q + pb1_q;
  assign num2_d = (pa2_q > pb2_q) ? pa2_q - pb2_q : pb2_q - pa2_q;
  assign den2_d = pa2_q + pb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
    end else if (adv) begin
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num1_q  <= num1_d;
      den1_q  <= den1_d;
      num2_q  <= num2_d;
      den2_q  <= den2_d;
      sat1_q  <= (den1_d == '0) || (num1_d >= den1_d);
      sat2_q  <= (den2_d == '0) || (num2_d >= den2_d);
      tir10_q <= tir9_q;
    end
  end

  // Fresnel quotients |Rs| and |Rp| in Q30.
  flag_t                side10;
  logic                 v11a, v11b, sat2_11;
  logic [WORK_BITS-1:0] rs11, rp11;
  logic [$bits(flag_t)-1:0] side11_raw;
  flag_t                side11;

  always_comb begin
    side10.tir = tir10_q;
    side10.sat = sat1_q;
  end

  frd_div #(
    .DEN_W  (ProdW),
    .SIDE_W ($bits(flag_t))
  ) u_div_rs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v10_q),
    .num_i   (num1_q),
    .low_i   ('0),
    .den_i   (den1_q),
    .side_i  (side10),
    .valid_o (v11a),
    .quo_o   (rs11),
    .side_o  (side11_raw)
  );
  assign side11 = flag_t'(side11_raw);

  frd_div #(
    .DEN_W  (ProdW),
    .SIDE_W (1)
  ) u_div_rp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v10_q),
    .num_i   (num2_q),
    .low_i   ('0),
    .den_i   (den2_q),
    .side_i  (sat2_q),
    .valid_o (v11b),
    .quo_o   (rp11),
    .side_o  (sat2_11)
  );

  // Stage 11: square both terms; a saturated term counts as one.
  logic              v12_q, tir12_q;
  logic [ROOT_W-1:0] r1, r2;
  logic [RAD_W-1:0]  sq1_q, sq2_q;

  assign r1 = side11.sat ? ROOT_W'(1) << WORK_BITS : {1'b0, rs11};
  assign r2 = sat2_11    ? ROOT_W'(1) << WORK_BITS : {1'b0, rp11};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q <= 1'b0;
    end else if (adv) begin
      v12_q <= v11a && v11b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq1_q   <= r1 * r1;
      sq2_q   <= r2 * r2;
      tir12_q <= side11.tir;
    end
  end

  // Output register: mean of the squares, Q60 truncated to Q16.
  logic [RAD_W-1:0] sum;
  logic             out_valid_q, tir_q;
  logic [16:0]      refl_q;

  assign sum = sq1_q + sq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      refl_q <= tir12_q ? 17'h10000 : sum[61:45];
      tir_q  <= tir12_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reflectance_o    = refl_q;
  assign total_internal_o = tir_q;

endmodule

FILE: sv/frd_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module frd_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [frd_pkg::RAD_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [frd_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]         side_o
);
  import frd_pkg::*;

  localparam int RemW = ROOT_W + 2;

  logic              vld_q  [ROOT_W];
  logic [RemW-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [RemW-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [RemW-1:0]   cur;
    logic [RemW-1:0]   trial;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign cur   = {rem_in[RemW-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[k]  <= cur - trial;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur;
          root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

FILE: sv/frd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module frd_div #(
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [DEN_W-1:0]              num_i,
  input  logic [frd_pkg::WORK_BITS-1:0] low_i,
  input  logic [DEN_W-1:0]              den_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [frd_pkg::WORK_BITS-1:0] quo_o,
  output logic [SIDE_W-1:0]             side_o
);
  import frd_pkg::*;

  logic                 vld_q  [WORK_BITS];
  logic [DEN_W-1:0]     rem_q  [WORK_BITS];
  logic [WORK_BITS-1:0] quo_q  [WORK_BITS];
  logic [WORK_BITS-1:0] low_q  [WORK_BITS];
  logic [DEN_W-1:0]     den_q  [WORK_BITS];
  logic [SIDE_W-1:0]    side_q [WORK_BITS];

  for (genvar k = 0; k < WORK_BITS; k++) begin : g_stage
    logic                 v_in;
    logic [DEN_W-1:0]     rem_in;
    logic [WORK_BITS-1:0] quo_in;
    logic [WORK_BITS-1:0] low_in;
    logic [DEN_W-1:0]     den_in;
    logic [SIDE_W-1:0]    side_in;
    logic [DEN_W:0]       cur;
    logic [DEN_W:0]       diff;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign low_in  = low_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign low_in  = low_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign cur  = {rem_in, low_in[WORK_BITS-1]};
    assign diff = cur - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= {1'b0, den_in}) begin
          rem_q[k] <= diff[DEN_W-1:0];
          quo_q[k] <= {quo_in[WORK_BITS-2:0], 1'b1};
        end else begin
          rem_q[k] <= cur[DEN_W-1:0];
          quo_q[k] <= {quo_in[WORK_BITS-2:0], 1'b0};
        end
        low_q[k]  <= low_in << 1;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[WORK_BITS-1];
  assign quo_o   = quo_q[WORK_BITS-1];
  assign side_o  = side_q[WORK_BITS-1];

endmodule

FILE: bench/tb.sv
// Testbench for the Fresnel reflectance pipeline: directed table, then random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frd_pkg::*;

  localparam int FB        = 14;
  localparam int LATENCY   = 131;
  localparam int WATCHDOG  = 20000;
  localparam int N_RANDOM  = 555;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [15:0] ix, iy, iz, nx, ny, nz;
  } ray_req_t;

  typedef struct packed {
    logic [16:0] refl;
    logic        tir;
  } refl_res_t;

  // Directed row: request, and a typed-in result where one is obvious.
  typedef struct {
    ray_req_t  req;
    logic      known;
    refl_res_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ray_req_t req_q = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [16:0] reflectance_o;
  logic total_internal_o;

  always #1 clk_i = ~clk_i;

  fresnel_reflectance_dielectric #(.FRACTION_BITS(FB)) dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .incident_x_i(req_q.ix), .incident_y_i(req_q.iy), .incident_z_i(req_q.iz),
    .normal_x_i(req_q.nx), .normal_y_i(req_q.ny), .normal_z_i(req_q.nz),
    .out_valid_o, .out_ready_i, .reflectance_o, .total_internal_o
  );

  // Material index as the predictor sees it; mirrors every register write.
  logic [15:0] material_index = INDEX_RESET;
  refl_res_t   pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          recv_idle_pct = 0;

  // Floor square root of a value below 2^61.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Squared Fresnel coefficient in Q60: ((a-b)/(a+b))^2, magnitude 1 if degenerate.
  function automatic logic [63:0] fresnel_term_sq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] num, den, q;
    logic [127:0] wide;
    num = (a > b) ? a - b : b - a;
    den = a + b;
    if (den == 0 || num >= den) begin
      q = 64'd1 << WORK_BITS;
    end else begin
      wide = {64'd0, num} << WORK_BITS;
      q = 64'(wide / {64'd0, den});
    end
    return q * q;
  endfunction

  function automatic refl_res_t predict_reflectance(input ray_req_t r);
    logic signed [63:0] dot;
    logic [63:0] mag, c, s, eta_i, eta_t, sin_t, cos_t, sum;
    refl_res_t res;
    dot = 64'(r.ix) * 64'(r.nx) + 64'(r.iy) * 64'(r.ny) + 64'(r.iz) * 64'(r.nz);
    mag = (dot < 0) ? 64'(-dot) : 64'(dot);
    if (mag > (64'd1 << (2 * FB))) mag = 64'd1 << (2 * FB);
    c = mag << (WORK_BITS - 2 * FB);
    // Leaving the material: swap the indices.
    if (dot > 0) begin
      eta_i = material_index;
      eta_t = INDEX_ONE;
    end else begin
      eta_i = INDEX_ONE;
      eta_t = material_index;
    end
    s = floor_sqrt((64'd1 << 60) - c * c);
    if (s * eta_i >= (eta_t << WORK_BITS)) begin
      res.refl = 17'd65536;
      res.tir  = 1'b1;
      return res;
    end
    sin_t = (s * eta_i) / eta_t;
    cos_t = floor_sqrt((64'd1 << 60) - sin_t * sin_t);
    sum = fresnel_term_sq(eta_t * c, eta_i * cos_t) + fresnel_term_sq(eta_i * c, eta_t * cos_t);
    res.refl = 17'(sum >> 45);
    res.tir  = 1'b0;
    return res;
  endfunction

  // Receiver: random stall, check against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected result refl=%0d tir=%0b", reflectance_o, total_internal_o);
        end else begin
          refl_res_t want;
          want = pending_results.pop_front();
          if (reflectance_o !== want.refl || total_internal_o !== want.tir) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("mismatch: refl exp %0d got %0d, tir exp %0b got %0b",
                       want.refl, reflectance_o, want.tir, total_internal_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles with no accepted request on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drive one request, idling first with the given percentage; predict on accept.
  task automatic send_request(input ray_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_q      <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_reflectance(r));
  endtask

  // Hold the sender until every result is back, then let the pipe drain.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_material_index(input logic [15:0] idx);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= idx;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    material_index  = idx;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32768)) - 16384); // within unit range
      2: return 16'($signed($urandom_range(23170)) - 11585);
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Mostly normalized-ish pairs so both TIR and partial paths are reached.
  function automatic ray_req_t rand_request();
    ray_req_t r;
    r.ix = rand_comp(); r.iy = rand_comp(); r.iz = rand_comp();
    r.nx = rand_comp(); r.ny = rand_comp(); r.nz = rand_comp();
    if ($urandom_range(3) == 0) begin
      r.iy = '0; r.iz = '0; r.ny = '0; r.nz = '0;
      r.ix = 16'($urandom_range(16384));
      r.nx = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    end
    return r;
  endfunction

  dir_row_t directed_rows[12] = '{
    // Normal incidence from outside at 1.5: ((1.5-1)/(2.5))^2 = 0.04.
    '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
    // Zero dot product, grazing: full reflection without TIR.
    '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, '{17'd65536, 1'b0}},
    // Leaving the material at grazing angle: total internal reflection.
    '{'{16'sd16384, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b1, '{17'd65536, 1'b1}},
    // Leaving at normal incidence.
    '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
    // Unnormalized extremes, clamped dot product.
    '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0, '0},
    // All-zero vectors.
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{17'd65536, 1'b0}},
    // 45 degrees in and out, then a near-grazing ray entering.
    '{'{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
    '{'{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, '0},
    '{'{-16'sd1, -16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b0, '0}
  };

  // Index settings swept within each random phase; extremes and zero included.
  logic [15:0] index_sweep[5] = '{16'd16384, 16'd65535, 16'd0, 16'd20000, 16'd24576};

  initial begin
    refl_res_t expected;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset index, no idling on the sender.
    recv_idle_pct = 0;
    foreach (directed_rows[i]) begin
      expected = predict_reflectance(directed_rows[i].req);
      if (directed_rows[i].known && expected !== directed_rows[i].res) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("table row %0d: exp refl %0d tir %0b, predicted refl %0d tir %0b",
                   i, directed_rows[i].res.refl, directed_rows[i].res.tir,
                   expected.refl, expected.tir);
      end
      send_request(directed_rows[i].req, 0);
    end
    drain_pipeline();

    // Random phases: sender idles 20 / receiver 85, then swapped, then none.
    for (int ph = 0; ph < 3; ph++) begin
      int send_idle_pct;
      send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 20 : 0;
      foreach (index_sweep[k]) begin
        write_material_index(index_sweep[k]);
        for (int n = 0; n < N_RANDOM / 15; n++)
          send_request(rand_request(), send_idle_pct);
        // The directed extremes again under this index.
        foreach (directed_rows[i]) send_request(directed_rows[i].req, send_idle_pct);
        drain_pipeline();
      end
    end

    // Leftover expectations at the end count as failures.
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
